>>> rtl/smm_pkg.sv
// Shared types and constants of the square matrix multiply block.
package smm_pkg;

   localparam int ElemWidth  = 16;
   localparam int ProdWidth  = 2 * ElemWidth;
   localparam int SumWidth   = 38;
   localparam int IdxWidth   = 6;
   localparam int SizeWidth  = 7;
   localparam int ReqWidth   = 32;
   localparam int RspWidth   = 56;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   typedef enum logic [1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_READ_C  = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef enum logic {
      REG_SIZE_IN_USE = 1'b0,
      REG_UNUSED      = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic req_accept;
      logic op_read;
      logic mac_busy;
      logic out_free;
   } seq_status_type;

   typedef struct packed {
      logic ready;
      logic start;
      logic issue;
      logic load;
   } seq_ctrl_type;

endpackage

>>> rtl/smm_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate.
module smm_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear,
   input  logic                                in_valid,
   input  logic signed [smm_pkg::ElemWidth-1:0] a,
   input  logic signed [smm_pkg::ElemWidth-1:0] b,
   output logic signed [smm_pkg::SumWidth-1:0]  sum,
   output logic                                busy
);

   logic signed [smm_pkg::ProdWidth-1:0] prod_ff, prod_in;
   logic                                 prod_vld_ff, prod_vld_in;
   logic signed [smm_pkg::SumWidth-1:0]  sum_ff, sum_in;

   always_comb begin
      prod_in     = a * b;
      prod_vld_in = in_valid;
      if (clear) begin
         sum_in = '0;
      end else if (prod_vld_ff) begin
         sum_in = sum_ff + smm_pkg::SumWidth'(prod_ff);
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign sum  = sum_ff;
   assign busy = prod_vld_ff;

endmodule

>>> rtl/smm_seq.sv
// Sequencer that steps the shared unit over one row and one column.
module smm_seq #(
   parameter int DIM = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  smm_pkg::seq_status_type       status,
   input  logic [$clog2(DIM+1)-1:0]      limit,
   output smm_pkg::seq_ctrl_type         ctrl
);

   localparam int KW = $clog2(DIM + 1);

   smm_pkg::state_type state_ff, state_in;
   logic [KW-1:0]      count_ff, count_in;
   logic [KW-1:0]      limit_ff, limit_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smm_pkg::ST_IDLE: begin
            if (status.req_accept && status.op_read) begin
               state_in = (limit != '0) ? smm_pkg::ST_ISSUE : smm_pkg::ST_DRAIN;
            end
         end
         smm_pkg::ST_ISSUE: begin
            if (count_ff == limit_ff - KW'(1)) begin
               state_in = smm_pkg::ST_DRAIN;
            end
         end
         smm_pkg::ST_DRAIN: begin
            if (!status.mac_busy) begin
               state_in = smm_pkg::ST_FINISH;
            end
         end
         smm_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = smm_pkg::ST_IDLE;
            end
         end
         default: state_in = smm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl       = '0;
      count_in   = count_ff;
      limit_in   = limit_ff;
      unique case (state_ff)
         smm_pkg::ST_IDLE: begin
            ctrl.ready = 1'b1;
            if (status.req_accept && status.op_read) begin
               ctrl.start = 1'b1;
               count_in   = '0;
               limit_in   = limit;
            end
         end
         smm_pkg::ST_ISSUE: begin
            ctrl.issue = 1'b1;
            count_in   = count_ff + KW'(1);
         end
         smm_pkg::ST_DRAIN: begin
         end
         smm_pkg::ST_FINISH: begin
            ctrl.load = status.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      count_ff <= count_in;
      limit_ff <= limit_in;
   end

endmodule

>>> rtl/square_matrix_multiply.sv
// Top level of the square matrix multiply block: stores, register port, result register.
// A write transaction (opcode 0 or 1) stores one element. A read transaction (opcode 2)
// makes n multiply-accumulates, n being size_in_use capped at DIM: one per term through
// the single shared multiplier, fed by one read port on each element store, then the
// pipeline drains. The input is not ready while a read is in progress; the finished
// result waits in an output register, so the next transaction is taken while it is
// pending. Element stores have no reset.
module square_matrix_multiply #(
   parameter int DIM = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [5:0] row, [11:6] col, [27:12] value, [31:28] zero
   input  logic [smm_pkg::ReqWidth-1:0]      req_tdata,
   // [1:0] opcode
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [37:0] product_element, [43:38] out_row, [49:44] out_col, [55:50] zero
   output logic [smm_pkg::RspWidth-1:0]      rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [smm_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [smm_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [smm_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);

   localparam int AW    = $clog2(DIM * DIM);
   localparam int KW    = $clog2(DIM + 1);
   localparam int DEPTH = DIM * DIM;

   logic [smm_pkg::ElemWidth-1:0] left_matrix  [DEPTH];
   logic [smm_pkg::ElemWidth-1:0] right_matrix [DEPTH];

   logic [smm_pkg::IdxWidth-1:0]   req_row, req_col;
   logic [smm_pkg::ElemWidth-1:0]  req_value;
   smm_pkg::opcode_type            req_op;
   logic                           req_accept, in_range;
   logic [AW-1:0]                  wr_addr;

   logic [smm_pkg::SizeWidth-1:0]  size_ff, size_in;
   logic [KW-1:0]                  limit;

   logic [AW-1:0]                  a_addr_ff, a_addr_in, b_addr_ff, b_addr_in;
   logic [smm_pkg::ElemWidth-1:0]  a_rd_ff, b_rd_ff;
   logic                           rd_vld_ff, rd_vld_in;
   logic [smm_pkg::IdxWidth-1:0]   row_ff, row_in, col_ff, col_in;

   logic signed [smm_pkg::SumWidth-1:0] sum;
   logic                                mac_busy;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [smm_pkg::RspWidth-1:0]   rsp_data_ff, rsp_data_in;

   smm_pkg::seq_status_type        status;
   smm_pkg::seq_ctrl_type          ctrl;

   assign req_row    = req_tdata[5:0];
   assign req_col    = req_tdata[11:6];
   assign req_value  = req_tdata[27:12];
   assign req_op     = smm_pkg::opcode_type'(req_tuser);
   assign req_tready = ctrl.ready;
   assign req_accept = req_tvalid && req_tready;
   assign in_range   = (int'(req_row) < DIM) && (int'(req_col) < DIM);
   assign wr_addr    = AW'(req_row) * AW'(DIM) + AW'(req_col);

   // register port
   always_comb begin
      size_in = size_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          smm_pkg::reg_index_type'(csr_paddr[2]) == smm_pkg::REG_SIZE_IN_USE) begin
         size_in = csr_pwdata[smm_pkg::SizeWidth-1:0];
      end
      if (smm_pkg::reg_index_type'(csr_paddr[2]) == smm_pkg::REG_SIZE_IN_USE) begin
         csr_prdata = smm_pkg::CsrDataWidth'(size_ff);
      end else begin
         csr_prdata = '0;
      end
   end
   assign csr_pready = 1'b1;

   always_comb begin
      if (!in_range) begin
         limit = '0;
      end else if (int'(size_ff) > DIM) begin
         limit = KW'(DIM);
      end else begin
         limit = KW'(size_ff);
      end
   end

   // element stores
   always_ff @(posedge clock) begin
      if (req_accept && in_range && req_op == smm_pkg::OP_WRITE_A) begin
         left_matrix[wr_addr] <= req_value;
      end
      if (req_accept && in_range && req_op == smm_pkg::OP_WRITE_B) begin
         right_matrix[wr_addr] <= req_value;
      end
      a_rd_ff <= left_matrix[a_addr_ff];
      b_rd_ff <= right_matrix[b_addr_ff];
   end

   always_comb begin
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      rd_vld_in = ctrl.issue;
      if (ctrl.start) begin
         a_addr_in = AW'(req_row) * AW'(DIM);
         b_addr_in = AW'(req_col);
         row_in    = req_row;
         col_in    = req_col;
      end else if (ctrl.issue) begin
         a_addr_in = a_addr_ff + AW'(1);
         b_addr_in = b_addr_ff + AW'(DIM);
      end
   end

   smm_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .clear    (ctrl.start),
      .in_valid (rd_vld_ff),
      .a        (a_rd_ff),
      .b        (b_rd_ff),
      .sum      (sum),
      .busy     (mac_busy)
   );

   assign status.req_accept = req_accept;
   assign status.op_read    = (req_op == smm_pkg::OP_READ_C);
   assign status.mac_busy   = mac_busy || rd_vld_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   smm_seq #(
      .DIM (DIM)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .limit  (limit),
      .ctrl   (ctrl)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b0, col_ff, row_ff, sum};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= smm_pkg::SizeWidth'(64);
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
      end
      a_addr_ff   <= a_addr_in;
      b_addr_ff   <= b_addr_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> tb/sv/tb_square_matrix_multiply.sv
// Testbench for square_matrix_multiply: directed and random traffic against a predictor.
`timescale 1ns / 1ps

module tb_square_matrix_multiply;
   import smm_pkg::*;

   localparam int DIM          = 64;
   localparam int HALF_PERIOD  = 4;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE       = DIM + 16;
   localparam int RANDOM_ITEMS = 440;
   localparam int PRINT_LIMIT  = 40;

   typedef struct {
      logic [SumWidth-1:0] product;
      logic [IdxWidth-1:0] row;
      logic [IdxWidth-1:0] col;
   } product_entry_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqWidth-1:0]     req_tdata;
   logic [1:0]              req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspWidth-1:0]     rsp_tdata;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   logic [ElemWidth-1:0] left_store  [DIM*DIM];
   logic [ElemWidth-1:0] right_store [DIM*DIM];
   bit                   left_known  [DIM*DIM];
   bit                   right_known [DIM*DIM];
   int unsigned          size_reg = 64;

   product_entry_type pending_products [$];
   int unsigned    items_count    = 0;
   int unsigned    mismatch_count = 0;
   int unsigned    cycle_count    = 0;
   int unsigned    burst_left     = 0;
   bit             no_gaps        = 1'b0;

   int unsigned stall_mode = 0;
   int unsigned mode_left  = 0;
   int unsigned hold_left  = 0;
   bit          hold_ready = 1'b0;

   square_matrix_multiply #(.DIM(DIM)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   function automatic logic [SumWidth-1:0] dot_product(int unsigned row, int unsigned col);
      longint      acc;
      int unsigned n;
      acc = 0;
      n = (size_reg > DIM) ? DIM : size_reg;
      for (int unsigned k = 0; k < n; k++)
         acc += longint'($signed(left_store[row*DIM+k])) *
                longint'($signed(right_store[k*DIM+col]));
      return acc[SumWidth-1:0];
   endfunction

   function automatic logic [ElemWidth-1:0] pick_element();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return ElemWidth'($urandom());
      endcase
   endfunction

   // result side: stall pattern switches at random among four modes
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(100, 500);
         hold_left  = 0;
      end
      mode_left--;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (mode_left % 6 == 0);
         default: begin
            if (hold_left == 0) begin
               hold_ready = !hold_ready;
               hold_left  = hold_ready ? $urandom_range(1, 6) : $urandom_range(10, 60);
            end
            hold_left--;
            rsp_tready <= hold_ready;
         end
      endcase
   end

   always @(posedge clock) begin : check_products
      product_entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_products.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_tdata), 64'd0);
         end else begin
            want = pending_products.pop_front();
            if (rsp_tdata[37:0] !== want.product)
               report_mismatch("product_element", 64'(rsp_tdata[37:0]), 64'(want.product));
            if (rsp_tdata[43:38] !== want.row)
               report_mismatch("out_row", 64'(rsp_tdata[43:38]), 64'(want.row));
            if (rsp_tdata[49:44] !== want.col)
               report_mismatch("out_col", 64'(rsp_tdata[49:44]), 64'(want.col));
         end
      end
   end

   task automatic send_item(opcode_type op, int unsigned row, int unsigned col,
                            logic [ElemWidth-1:0] value);
      product_entry_type entry;
      int unsigned    gap_len;
      gap_len = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (!no_gaps && $urandom_range(0, 3) != 0)
            gap_len = $urandom_range(1, 10);
      end
      burst_left--;
      @(negedge clock);
      if (gap_len > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_len) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0000, value, IdxWidth'(col), IdxWidth'(row)};
      do @(posedge clock); while (!req_tready);
      case (op)
         OP_WRITE_A: begin
            left_store[row*DIM+col] = value;
            left_known[row*DIM+col] = 1'b1;
         end
         OP_WRITE_B: begin
            right_store[row*DIM+col] = value;
            right_known[row*DIM+col] = 1'b1;
         end
         OP_READ_C: begin
            entry.product = dot_product(row, col);
            entry.row     = IdxWidth'(row);
            entry.col     = IdxWidth'(col);
            pending_products.push_back(entry);
         end
         default: ;
      endcase
      items_count++;
   endtask

   task automatic wait_until_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_products.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type which, logic [CsrDataWidth-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrWidth'(4 * which);
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (which == REG_SIZE_IN_USE)
         size_reg = data[SizeWidth-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read_check(reg_index_type which, logic [CsrDataWidth-1:0] want);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CsrAddrWidth'(4 * which);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         report_mismatch("size_in_use readback", 64'(csr_prdata), 64'(want));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_size(int unsigned n);
      wait_until_idle();
      csr_write(REG_SIZE_IN_USE, n);
      csr_read_check(REG_SIZE_IN_USE, n);
   endtask

   // fill whatever the dot product needs and has never been written, then read
   task automatic prepare_and_read(int unsigned row, int unsigned col);
      int unsigned n;
      n = (size_reg > DIM) ? DIM : size_reg;
      for (int unsigned k = 0; k < n; k++) begin
         if (!left_known[row*DIM+k])
            send_item(OP_WRITE_A, row, k, pick_element());
         if (!right_known[k*DIM+col])
            send_item(OP_WRITE_B, k, col, pick_element());
      end
      send_item(OP_READ_C, row, col, ElemWidth'($urandom()));
   endtask

   task automatic fill_and_read(int unsigned row, int unsigned col,
                                logic [ElemWidth-1:0] a_val, logic [ElemWidth-1:0] b_val);
      for (int unsigned k = 0; k < DIM; k++) begin
         send_item(OP_WRITE_A, row, k, a_val);
         send_item(OP_WRITE_B, k, col, b_val);
      end
      send_item(OP_READ_C, row, col, 16'h0000);
   endtask

   task automatic test_register_access();
      csr_read_check(REG_SIZE_IN_USE, 64);
      set_size(1);
      set_size(127);
      set_size(0);
      set_size(65);
      set_size(64);
   endtask

   task automatic test_extreme_products();
      set_size(2);
      send_item(OP_WRITE_A, 0, 0, 16'h7FFF);
      send_item(OP_WRITE_A, 0, 1, 16'h8000);
      send_item(OP_WRITE_B, 0, 0, 16'h8000);
      send_item(OP_WRITE_B, 1, 0, 16'h8000);
      send_item(OP_READ_C, 0, 0, 16'hFFFF);
      send_item(OP_WRITE_A, 63, 0, 16'h8000);
      send_item(OP_WRITE_A, 63, 1, 16'h8000);
      send_item(OP_WRITE_B, 0, 63, 16'h7FFF);
      send_item(OP_WRITE_B, 1, 63, 16'h8000);
      send_item(OP_READ_C, 63, 63, 16'h0000);
      // index beyond the size still sums the stored elements
      send_item(OP_READ_C, 0, 63, 16'h5555);
      send_item(OP_READ_C, 63, 0, 16'hAAAA);
   endtask

   task automatic test_size_zero();
      set_size(0);
      send_item(OP_READ_C, 5, 7, 16'hFFFF);
      send_item(OP_READ_C, 63, 0, 16'h0000);
   endtask

   task automatic test_ignored_opcode();
      set_size(2);
      send_item(OP_NONE, 0, 0, 16'h1234);
      send_item(OP_NONE, 63, 63, 16'hFFFF);
      send_item(OP_NONE, 0, 1, 16'h0000);
      send_item(OP_READ_C, 0, 0, 16'h0000);
   endtask

   task automatic test_largest_sums();
      set_size(64);
      fill_and_read(62, 62, 16'h8000, 16'h8000);
      fill_and_read(61, 61, 16'h8000, 16'h7FFF);
      // sizes above DIM saturate
      set_size(127);
      prepare_and_read(62, 62);
      set_size(65);
      prepare_and_read(61, 61);
   endtask

   task automatic test_random_traffic();
      int unsigned start_count;
      int unsigned phase;
      int unsigned n;
      int unsigned op_len;
      int unsigned choice;
      start_count = items_count;
      phase = 0;
      while (items_count - start_count < RANDOM_ITEMS) begin
         case (phase)
            0: n = 1;
            1: n = 127;
            2: n = 64;
            default: begin
               if ($urandom_range(0, 9) == 0) begin
                  case ($urandom_range(0, 2))
                     0: n = 0;
                     1: n = 64;
                     default: n = $urandom_range(65, 127);
                  endcase
               end else begin
                  n = $urandom_range(1, 8);
               end
            end
         endcase
         set_size(n);
         no_gaps = ($urandom_range(0, 4) == 0);
         op_len = (n > 8) ? $urandom_range(2, 4) : $urandom_range(15, 50);
         repeat (op_len) begin
            choice = $urandom_range(0, 99);
            if (choice < 65) begin
               if (n > 8)
                  prepare_and_read($urandom_range(0, 1) ? 63 : $urandom_range(0, DIM - 1),
                                   $urandom_range(0, 1) ? 0 : $urandom_range(0, DIM - 1));
               else
                  prepare_and_read($urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1));
            end else if (choice < 92) begin
               send_item(opcode_type'($urandom_range(0, 1)), $urandom_range(0, DIM - 1),
                         $urandom_range(0, DIM - 1), pick_element());
            end else begin
               send_item(OP_NONE, $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
                         ElemWidth'($urandom()));
            end
         end
         phase++;
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_NONE;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_access();
      test_extreme_products();
      test_size_zero();
      test_ignored_opcode();
      test_largest_sums();
      test_random_traffic();

      wait_until_idle();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> square_matrix_multiply.f
rtl/smm_pkg.sv
rtl/smm_mac.sv
rtl/smm_seq.sv
rtl/square_matrix_multiply.sv
tb/sv/tb_square_matrix_multiply.sv
